/* rtl/kslpd_pkg.sv */
package kslpd_pkg;

    localparam int NUM_KEYS = 3;
    localparam int TIME_W   = 32;

    // Key machine modes. The released mode only exists inside one poll.
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_DOWN     = 2'd1;
    localparam logic [1:0] MODE_RELEASED = 2'd2;
    localparam logic [1:0] MODE_LONG     = 2'd3;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_THR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_THR  = 1'd1;

    localparam logic [TIME_W-1:0] SHORT_THR_RST = 32'd50;
    localparam logic [TIME_W-1:0] LONG_THR_RST  = 32'd3000;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int S_FIELDS_W = NUM_KEYS + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * NUM_KEYS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic [NUM_KEYS-1:0] short_mask;
        logic [NUM_KEYS-1:0] long_mask;
    } kslpd_evt_t;

endpackage

/* rtl/kslpd_lane.sv */
module kslpd_lane
    import kslpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              held,
    input  logic [TIME_W-1:0] now_ticks,
    input  logic [TIME_W-1:0] short_thr,
    input  logic [TIME_W-1:0] long_thr,
    output logic              short_evt,
    output logic              long_evt
);

    logic [1:0]        mode_reg;
    logic [1:0]        mode_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = now_ticks - start_reg;

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        short_evt  = 1'b0;
        long_evt   = 1'b0;
        unique case (mode_reg)
            MODE_DOWN, MODE_LONG: begin
                if (held) begin
                    if (elapsed >= long_thr) begin
                        long_evt   = 1'b1;
                        start_next = now_ticks;
                        mode_next  = MODE_LONG;
                    end
                end else begin
                    start_next = '0;
                    mode_next  = MODE_IDLE;
                    // Only a release straight from down reports anything.
                    if (mode_reg == MODE_DOWN) begin
                        if (elapsed >= long_thr) begin
                            long_evt = 1'b1;
                        end else if (elapsed >= short_thr) begin
                            short_evt = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // Idle: a fresh press has zero held time, so only a zero
                // long threshold fires on the press poll itself.
                if (held) begin
                    start_next = now_ticks;
                    if (long_thr == '0) begin
                        long_evt  = 1'b1;
                        mode_next = MODE_LONG;
                    end else begin
                        mode_next = MODE_DOWN;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(short_evt && long_evt))
        else $error("lane reports short and long in the same poll");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && long_evt && held |=> mode_reg == MODE_LONG && start_reg == $past(now_ticks))
        else $error("long event while held did not restart the timer");
`endif

endmodule

/* rtl/kslpd_merge.sv */
module kslpd_merge
    import kslpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [NUM_KEYS-1:0]  lane_short,
    input  logic [NUM_KEYS-1:0]  lane_long,
    output logic                 in_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output kslpd_evt_t           m_evt
);

    kslpd_evt_t evt_new;
    kslpd_evt_t out_reg;
    kslpd_evt_t skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;

    assign evt_new.short_mask = lane_short;
    assign evt_new.long_mask  = lane_long;

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_evt    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else if (!in_fire) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg) begin
                out_valid_reg <= in_fire;
            end else if (in_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_fire) begin
                out_reg <= evt_new;
            end
        end else if (!out_valid_reg) begin
            if (in_fire) begin
                out_reg <= evt_new;
            end
        end else if (in_fire) begin
            skid_reg <= evt_new;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held while output stage is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> out_valid_reg)
        else $error("accepted poll produced no result beat");
`endif

endmodule

/* rtl/key_short_long_press_detector_core.sv */
// Channel | Ports                        | Beat contents (low bit up)
// input   | s_tvalid s_tready s_tdata    | keys_pressed[2:0], now_ticks[34:3]
// result  | m_tvalid m_tready m_tdata    | short_press_mask[2:0], long_press_mask[5:3]
// config  | cfg_wr_en cfg_addr cfg_wdata | 0 short_threshold, 1 long_threshold
//
// One poll per clock while s_tready is high; every key lane updates in the cycle the beat is accepted.
// The result beat is registered and comes from the output register.
// A one-entry skid stage lets one more poll in while the output is stalled;
// s_tready drops only while that skid entry is occupied.
// Reset (aresetn low, synchronous) puts all keys idle and restores thresholds.
module key_short_long_press_detector_core
    import kslpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // keys_pressed, now_ticks, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // short_press_mask, long_press_mask, zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [TIME_W-1:0]   short_thr_reg;
    logic [TIME_W-1:0]   long_thr_reg;
    logic [NUM_KEYS-1:0] keys_pressed;
    logic [TIME_W-1:0]   now_ticks;
    logic [NUM_KEYS-1:0] lane_short;
    logic [NUM_KEYS-1:0] lane_long;
    logic                in_fire;
    kslpd_evt_t          m_evt;

    assign keys_pressed = s_tdata[NUM_KEYS-1:0];
    assign now_ticks    = s_tdata[NUM_KEYS +: TIME_W];
    assign in_fire      = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_thr_reg <= SHORT_THR_RST;
            long_thr_reg  <= LONG_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SHORT_THR: short_thr_reg <= cfg_wdata[TIME_W-1:0];
                REG_LONG_THR:  long_thr_reg  <= cfg_wdata[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kslpd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (in_fire),
            .held      (keys_pressed[k]),
            .now_ticks (now_ticks),
            .short_thr (short_thr_reg),
            .long_thr  (long_thr_reg),
            .short_evt (lane_short[k]),
            .long_evt  (lane_long[k])
        );
    end

    kslpd_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .lane_short (lane_short),
        .lane_long  (lane_long),
        .in_ready   (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_evt      (m_evt)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[NUM_KEYS-1:0]        = m_evt.short_mask;
        m_tdata[NUM_KEYS +: NUM_KEYS] = m_evt.long_mask;
    end

endmodule

/* verif/tb_key_short_long_press_detector_core.sv */
`timescale 1ns / 1ps

module tb_key_short_long_press_detector_core;
    import kslpd_pkg::*;

    typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [NUM_KEYS-1:0]   keys;
        logic [TIME_W-1:0]     now_val;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    typed;
        logic [NUM_KEYS-1:0]   exp_short;
        logic [NUM_KEYS-1:0]   exp_long;
    } dir_row_t;

    localparam int NUM_DIR_ROWS = 25;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: one mode and one start time per key, plus both thresholds.
    logic [1:0]        key_mode_q [NUM_KEYS];
    logic [TIME_W-1:0] key_start_q [NUM_KEYS];
    logic [TIME_W-1:0] short_thr_q;
    logic [TIME_W-1:0] long_thr_q;

    kslpd_evt_t pending_events [$];
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;
    dir_row_t   dir_rows [NUM_DIR_ROWS];

    key_short_long_press_detector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic kslpd_evt_t predict_press_events(input logic [NUM_KEYS-1:0] keys,
                                                        input logic [TIME_W-1:0] now_val);
        kslpd_evt_t        ev;
        logic [1:0]        mode;
        logic [TIME_W-1:0] held;
        ev = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            mode = key_mode_q[k];
            if (mode == MODE_RELEASED)
                mode = MODE_IDLE;
            if (mode == MODE_IDLE) begin
                if (keys[k]) begin
                    mode = MODE_DOWN;
                    key_start_q[k] = now_val;
                end
            end else if (mode == MODE_DOWN) begin
                if (!keys[k])
                    mode = MODE_RELEASED;
            end else if (!keys[k]) begin
                key_start_q[k] = '0;
                mode = MODE_IDLE;
            end
            if (mode == MODE_DOWN || mode == MODE_LONG) begin
                held = now_val - key_start_q[k];
                if (held >= long_thr_q) begin
                    key_start_q[k] = now_val;
                    mode = MODE_LONG;
                    ev.long_mask[k] = 1'b1;
                end
            end else if (mode == MODE_RELEASED) begin
                held = now_val - key_start_q[k];
                key_start_q[k] = '0;
                mode = MODE_IDLE;
                if (held >= short_thr_q && held < long_thr_q)
                    ev.short_mask[k] = 1'b1;
                else if (held >= long_thr_q)
                    ev.long_mask[k] = 1'b1;
            end
            key_mode_q[k] = mode;
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("tb: mismatch in %s: got %0h, expected %0h", what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        kslpd_evt_t ev;
        if (pending_events.size() == 0) begin
            report_mismatch("unexpected result beat", 32'(beat), 32'd0);
        end else begin
            ev = pending_events.pop_front();
            if (beat[NUM_KEYS-1:0] !== ev.short_mask)
                report_mismatch("short_press_mask", 32'(beat[NUM_KEYS-1:0]),
                                32'(ev.short_mask));
            if (beat[2*NUM_KEYS-1:NUM_KEYS] !== ev.long_mask)
                report_mismatch("long_press_mask", 32'(beat[2*NUM_KEYS-1:NUM_KEYS]),
                                32'(ev.long_mask));
        end
    endtask

    // Offers one poll beat, keeping tvalid high afterwards so back-to-back beats
    // need no extra assignment. The expectation is queued at the accepting edge.
    task automatic send_poll(input logic [NUM_KEYS-1:0] keys, input logic [TIME_W-1:0] now_val,
                             input bit typed, input logic [NUM_KEYS-1:0] exp_short,
                             input logic [NUM_KEYS-1:0] exp_long);
        kslpd_evt_t ev;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({now_val, keys});
        do @(posedge aclk); while (!s_tready);
        ev = predict_press_events(keys, now_val);
        if (typed) begin
            ev.short_mask = exp_short;
            ev.long_mask  = exp_long;
        end
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_events.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SHORT_THR)
            short_thr_q = val;
        else if (idx == REG_LONG_THR)
            long_thr_q = val;
    endtask

    // Keys mostly stay put and toggle now and then, so presses are held long
    // enough to cross the thresholds; time creeps forward with rare jumps.
    task automatic run_random(input int n_items, input bit pressure);
        logic [NUM_KEYS-1:0] keys;
        logic [TIME_W-1:0]   now_val;
        int                  step_lim;
        keys     = '0;
        now_val  = $urandom();
        step_lim = (long_thr_q > 60) ? 24 : int'(long_thr_q / 3) + 2;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                keys = NUM_KEYS'($urandom_range(0, 7));
            end else begin
                for (int k = 0; k < NUM_KEYS; k++)
                    if ($urandom_range(0, 3) == 0)
                        keys[k] = ~keys[k];
            end
            if ($urandom_range(0, 39) == 0)
                now_val = $urandom();
            else
                now_val = now_val + $urandom_range(0, step_lim);
            if (pressure && i == n_items / 3)
                hold_req = 1'b1;
            if (pressure && i == (2 * n_items) / 3) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_poll(keys, now_val, 1'b0, '0, '0);
        end
    endtask

    // Result side: checks accepted beats and drives tready, with an occasional
    // long hold-off so the block backs up into its input.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        short_thr_q = SHORT_THR_RST;
        long_thr_q  = LONG_THR_RST;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_mode_q[k]  = MODE_IDLE;
            key_start_q[k] = '0;
        end

        dir_rows = '{
            '{ROW_POLL,  3'd0, 32'd0,          REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd0},
            '{ROW_POLL,  3'd7, 32'd100,        REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd0},
            '{ROW_POLL,  3'd6, 32'd160,        REG_SHORT_THR, 32'd0, 1'b1, 3'd1, 3'd0},
            '{ROW_POLL,  3'd4, 32'd3100,       REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd6},
            '{ROW_POLL,  3'd4, 32'd6099,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd4, 32'd6100,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'd6200,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd1, 32'hFFFF_FFF0,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'h0000_0020,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd1, 32'hFFFF_FFF0,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'h0000_0022,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd2, 32'h0000_0100,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'h0000_0131,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd7, 32'hFFFF_FFFF,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'hFFFF_FFFF,  REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_WRITE, 3'd0, 32'd0,          REG_LONG_THR,  32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_WRITE, 3'd0, 32'd0,          REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd5, 32'd10,         REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd5},
            '{ROW_POLL,  3'd5, 32'd10,         REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd5},
            '{ROW_POLL,  3'd0, 32'd11,         REG_SHORT_THR, 32'd0, 1'b1, 3'd0, 3'd0},
            '{ROW_WRITE, 3'd0, 32'd0,          REG_SHORT_THR, 32'hFFFF_FFFF, 1'b0, 3'd0, 3'd0},
            '{ROW_WRITE, 3'd0, 32'd0,          REG_LONG_THR,  32'd1, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd3, 32'd1000,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd1, 32'd1000,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0},
            '{ROW_POLL,  3'd0, 32'd1001,       REG_SHORT_THR, 32'd0, 1'b0, 3'd0, 3'd0}
        };

        send_idle_pct = 26;
        recv_idle_pct = 58;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            else
                send_poll(dir_rows[i].keys, dir_rows[i].now_val, dir_rows[i].typed,
                          dir_rows[i].exp_short, dir_rows[i].exp_long);
        end

        write_reg(REG_SHORT_THR, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(REG_LONG_THR, CFG_DATA_W'($urandom_range(16, 48)));
        run_random(210, 1'b0);

        send_idle_pct = 58;
        recv_idle_pct = 26;
        // Short threshold may land above the long one here.
        write_reg(REG_SHORT_THR, CFG_DATA_W'($urandom_range(0, 40)));
        write_reg(REG_LONG_THR, CFG_DATA_W'($urandom_range(1, 40)));
        run_random(210, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SHORT_THR, '0);
        write_reg(REG_LONG_THR, '1);
        run_random(210, 1'b0);

        write_reg(REG_SHORT_THR, '1);
        write_reg(REG_LONG_THR, CFG_DATA_W'(1));
        run_random(210, 1'b0);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* key_short_long_press_detector_core.f */
rtl/kslpd_pkg.sv
rtl/kslpd_lane.sv
rtl/kslpd_merge.sv
rtl/key_short_long_press_detector_core.sv
verif/tb_key_short_long_press_detector_core.sv
